// ----- rtl/afr_pkg.sv -----
// shared types and constants for the addressed frame receiver
package afr_pkg;

  // parser phase
  typedef enum logic [2:0] {
    PH_WAIT = 3'd0,
    PH_ADDR = 3'd1,
    PH_LEN  = 3'd2,
    PH_DATA = 3'd3,
    PH_CHK  = 3'd4,
    PH_END  = 3'd5
  } phase_t;

  // reported status codes
  typedef enum logic [2:0] {
    ST_PAYLOAD  = 3'd0,
    ST_MISMATCH = 3'd1,
    ST_CHK_GOOD = 3'd2,
    ST_CHK_BAD  = 3'd3,
    ST_END_SEEN = 3'd4
  } status_t;

  // configuration register indexes
  localparam logic [1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [1:0] REG_START_BYTE     = 2'd1;
  localparam logic [1:0] REG_END_BYTE       = 2'd2;

  localparam logic [15:0] DEVICE_ADDRESS_RST = 16'h0000;
  localparam logic [7:0]  START_BYTE_RST     = 8'h02;
  localparam logic [7:0]  END_BYTE_RST       = 8'h03;

  typedef struct packed {
    logic [15:0] device_address;
    logic [7:0]  start_byte;
    logic [7:0]  end_byte;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    status_t    status;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
  } res_t;

endpackage

// ----- rtl/afr_in_stage.sv -----
// input register stage holding one received word
module afr_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       word_valid,
  output logic [7:0] word_byte,
  input  logic       consume
);

  logic       held;
  logic [7:0] held_byte;

  assign in_ready   = !held || consume;
  assign word_valid = held;
  assign word_byte  = held_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (consume) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

// ----- rtl/afr_parser.sv -----
// frame parser state and per-word decode
module afr_parser (
  input  logic          clk,
  input  logic          rst,
  input  afr_pkg::cfg_t cfg,
  input  logic          word_valid,
  input  logic [7:0]    word_byte,
  input  logic          slot_free,
  output logic          consume,
  output afr_pkg::res_t res
);

  afr_pkg::phase_t phase, phase_next;
  logic        addr_low_seen, addr_low_seen_next;
  logic [15:0] addr_received, addr_received_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [7:0]  bytes_received, bytes_received_next;
  logic [7:0]  running_sum, running_sum_next;
  logic [15:0] addr_full;
  logic [7:0]  count_inc;

  assign consume   = word_valid && slot_free;
  assign addr_full = {word_byte, addr_received[7:0]};
  assign count_inc = bytes_received + 8'd1;

  always_comb begin
    phase_next          = phase;
    addr_low_seen_next  = addr_low_seen;
    addr_received_next  = addr_received;
    frame_length_next   = frame_length;
    bytes_received_next = bytes_received;
    running_sum_next    = running_sum;
    res.valid           = 1'b0;
    res.status          = afr_pkg::ST_PAYLOAD;
    res.payload_byte    = 8'd0;
    res.payload_index   = 8'd0;
    case (phase)
      afr_pkg::PH_WAIT: begin
        if (word_byte == cfg.start_byte) begin
          running_sum_next    = 8'd0;
          addr_received_next  = 16'd0;
          addr_low_seen_next  = 1'b0;
          bytes_received_next = 8'd0;
          frame_length_next   = 8'd0;
          phase_next          = afr_pkg::PH_ADDR;
        end
      end
      afr_pkg::PH_ADDR: begin
        running_sum_next = running_sum + word_byte;
        if (!addr_low_seen) begin
          addr_received_next = {8'd0, word_byte};
          addr_low_seen_next = 1'b1;
        end else begin
          addr_received_next = addr_full;
          addr_low_seen_next = 1'b0;
          if (addr_full == cfg.device_address) begin
            phase_next = afr_pkg::PH_LEN;
          end else begin
            phase_next = afr_pkg::PH_WAIT;
            res.valid  = 1'b1;
            res.status = afr_pkg::ST_MISMATCH;
          end
        end
      end
      afr_pkg::PH_LEN: begin
        frame_length_next = word_byte;
        running_sum_next  = running_sum + word_byte;
        phase_next        = (word_byte == 8'd0) ? afr_pkg::PH_CHK : afr_pkg::PH_DATA;
      end
      afr_pkg::PH_DATA: begin
        bytes_received_next = count_inc;
        running_sum_next    = running_sum + word_byte;
        if (count_inc == frame_length) begin
          phase_next = afr_pkg::PH_CHK;
        end
        res.valid         = 1'b1;
        res.status        = afr_pkg::ST_PAYLOAD;
        res.payload_byte  = word_byte;
        res.payload_index = bytes_received;
      end
      afr_pkg::PH_CHK: begin
        phase_next = afr_pkg::PH_END;
        res.valid  = 1'b1;
        res.status = (running_sum == word_byte) ? afr_pkg::ST_CHK_GOOD
                                                : afr_pkg::ST_CHK_BAD;
      end
      afr_pkg::PH_END: begin
        phase_next = afr_pkg::PH_WAIT;
        if (word_byte == cfg.end_byte) begin
          res.valid  = 1'b1;
          res.status = afr_pkg::ST_END_SEEN;
        end
      end
      default: begin
        phase_next = afr_pkg::PH_WAIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= afr_pkg::PH_WAIT;
      addr_low_seen  <= 1'b0;
      addr_received  <= 16'd0;
      frame_length   <= 8'd0;
      bytes_received <= 8'd0;
      running_sum    <= 8'd0;
    end else if (consume) begin
      phase          <= phase_next;
      addr_low_seen  <= addr_low_seen_next;
      addr_received  <= addr_received_next;
      frame_length   <= frame_length_next;
      bytes_received <= bytes_received_next;
      running_sum    <= running_sum_next;
    end
  end

endmodule

// ----- rtl/afr_out_reg.sv -----
// result register on the output channel
module afr_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  afr_pkg::res_t res,
  input  logic          consume,
  output logic          slot_free,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    status,
  output logic [7:0]    payload_byte,
  output logic [7:0]    payload_index
);

  logic          full;
  afr_pkg::res_t held;

  assign slot_free     = !full || out_ready;
  assign out_valid     = full;
  assign status        = held.status;
  assign payload_byte  = held.payload_byte;
  assign payload_index = held.payload_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (slot_free) begin
      full <= consume && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && consume && res.valid) begin
      held <= res;
    end
  end

endmodule

// ----- rtl/addressed_frame_receiver_unit.sv -----
// addressed frame receiver: start byte, address, length, payload, checksum, end byte
// a word is registered in the input stage and its result in the result register;
// one word per cycle while the output register is read or empty; the output
// register frees in the cycle it is read
// reset (rst, synchronous, active high) returns the parser to waiting for a start
// byte and loads device_address 0, start_byte 2, end_byte 3
module addressed_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst,
  // received word channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  // result word channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  payload_byte,
  output logic [7:0]  payload_index,
  // configuration write port
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  afr_pkg::cfg_t cfg;
  afr_pkg::res_t res;
  logic          word_valid;
  logic [7:0]    word_byte;
  logic          consume;
  logic          slot_free;

  // configuration registers; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address <= afr_pkg::DEVICE_ADDRESS_RST;
      cfg.start_byte     <= afr_pkg::START_BYTE_RST;
      cfg.end_byte       <= afr_pkg::END_BYTE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        afr_pkg::REG_DEVICE_ADDRESS: cfg.device_address <= cfg_data;
        afr_pkg::REG_START_BYTE:     cfg.start_byte     <= cfg_data[7:0];
        afr_pkg::REG_END_BYTE:       cfg.end_byte       <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // input register, refilled in the same cycle it drains
  afr_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .word_valid (word_valid),
    .word_byte  (word_byte),
    .consume    (consume)
  );

  // parser: one state update per word, at most one result word
  afr_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .word_valid (word_valid),
    .word_byte  (word_byte),
    .slot_free  (slot_free),
    .consume    (consume),
    .res        (res)
  );

  // result register; a word with no result simply passes through the parser
  afr_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .res           (res),
    .consume       (consume),
    .slot_free     (slot_free),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .payload_byte  (payload_byte),
    .payload_index (payload_index)
  );

endmodule
